### rtl/sensor_change_reporter_assert.svh
// Assertion macros shared by the sensor change reporter RTL.
`ifndef SENSOR_CHANGE_REPORTER_ASSERT_SVH
`define SENSOR_CHANGE_REPORTER_ASSERT_SVH
// SCR_ASSERT_NOW: the consequent must hold in the same cycle as the antecedent.
// The SCR_ASSERT_NEXT macro requires the consequent to hold in the cycle after the antecedent.
`ifndef SYNTH
`define SCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sensor_change_reporter: assertion failed");
`define SCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sensor_change_reporter: assertion failed");
`else
`define SCR_ASSERT_NOW(label, ante, cons)
`define SCR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/scr_pkg.sv
// Shared types and constants of the sensor change reporter.
package scr_pkg;

    localparam logic [1:0] KIND_THERMAL  = 2'd0;
    localparam logic [1:0] KIND_PRESSURE = 2'd1;
    localparam logic [1:0] KIND_HUMIDITY = 2'd2;
    localparam logic [1:0] KIND_NOMINAL  = 2'd3;

    localparam logic [6:0] CONF_THERMAL  = 7'd88;
    localparam logic [6:0] CONF_PRESSURE = 7'd80;
    localparam logic [6:0] CONF_HUMIDITY = 7'd75;
    localparam logic [6:0] CONF_NOMINAL  = 7'd70;

    localparam logic [2:0] COMFORT_OK    = 3'd0;
    localparam logic [2:0] COMFORT_WARM  = 3'd1;
    localparam logic [2:0] COMFORT_COOL  = 3'd2;
    localparam logic [2:0] COMFORT_HUMID = 3'd3;
    localparam logic [2:0] COMFORT_DRY   = 3'd4;

    localparam logic signed [14:0] TEMP_OK_LOW  = 15'sd1800;
    localparam logic signed [14:0] TEMP_OK_HIGH = 15'sd2600;
    localparam logic [13:0]        HUM_OK_LOW   = 14'd3000;
    localparam logic [13:0]        HUM_OK_HIGH  = 14'd6500;

    localparam logic [1:0] REG_TEMP_THR  = 2'd0;
    localparam logic [1:0] REG_HUM_THR   = 2'd1;
    localparam logic [1:0] REG_PRES_THR  = 2'd2;
    localparam logic [1:0] REG_HEARTBEAT = 2'd3;

    localparam logic [13:0] TEMP_THR_RESET  = 14'd50;
    localparam logic [13:0] HUM_THR_RESET   = 14'd300;
    localparam logic [16:0] PRES_THR_RESET  = 17'd100;
    localparam logic [31:0] HEARTBEAT_RESET = 32'd300000;

    typedef struct packed {
        logic [14:0] temperature;
        logic [13:0] humidity;
        logic [16:0] pressure;
        logic [31:0] now_ms;
    } t_sample;

    typedef struct packed {
        logic [14:0] temperature;
        logic [13:0] humidity;
        logic [16:0] pressure;
        logic        have_previous;
        logic [31:0] last_report_time;
    } t_history;

    typedef struct packed {
        logic [13:0] temp_threshold;
        logic [13:0] hum_threshold;
        logic [16:0] pres_threshold;
        logic [31:0] heartbeat_interval;
    } t_cfg;

    typedef struct packed {
        logic        report;
        logic [1:0]  kind;
        logic        rising;
        logic [17:0] delta;
        logic [2:0]  comfort;
        logic [6:0]  confidence;
    } t_decision;

endpackage

### rtl/scr_eval.sv
// Change detection, priority select and comfort class for one sample.
module scr_eval
    import scr_pkg::*;
(
    input  t_sample   i_sample,
    input  t_history  i_hist,
    input  t_cfg      i_cfg,
    output t_decision o_dec
);

    logic signed [15:0] dt;
    logic signed [14:0] dh;
    logic signed [17:0] dp;
    logic [15:0]        mag_t;
    logic [14:0]        mag_h;
    logic [17:0]        mag_p;
    logic               first;
    logic               beat;
    logic               t_ch;
    logic               h_ch;
    logic               p_ch;
    logic               t_ok;
    logic               h_ok;
    logic [2:0]         comfort;
    logic [31:0]        elapsed;

    always_comb begin
        dt = $signed({i_sample.temperature[14], i_sample.temperature})
           - $signed({i_hist.temperature[14], i_hist.temperature});
        dh = $signed({1'b0, i_sample.humidity}) - $signed({1'b0, i_hist.humidity});
        dp = $signed({1'b0, i_sample.pressure}) - $signed({1'b0, i_hist.pressure});
        mag_t = dt[15] ? 16'(-dt) : 16'(dt);
        mag_h = dh[14] ? 15'(-dh) : 15'(dh);
        mag_p = dp[17] ? 18'(-dp) : 18'(dp);

        first   = !i_hist.have_previous;
        elapsed = i_sample.now_ms - i_hist.last_report_time;
        beat    = elapsed >= i_cfg.heartbeat_interval;
        t_ch    = !first && (mag_t >= {2'b00, i_cfg.temp_threshold});
        h_ch    = !first && (mag_h >= {1'b0, i_cfg.hum_threshold});
        p_ch    = !first && (mag_p >= {1'b0, i_cfg.pres_threshold});

        t_ok = ($signed(i_sample.temperature) >= TEMP_OK_LOW)
            && ($signed(i_sample.temperature) <= TEMP_OK_HIGH);
        h_ok = (i_sample.humidity >= HUM_OK_LOW) && (i_sample.humidity <= HUM_OK_HIGH);
        if (t_ok && h_ok) begin
            comfort = COMFORT_OK;
        end else if ($signed(i_sample.temperature) > TEMP_OK_HIGH) begin
            comfort = COMFORT_WARM;
        end else if ($signed(i_sample.temperature) < TEMP_OK_LOW) begin
            comfort = COMFORT_COOL;
        end else if (i_sample.humidity > HUM_OK_HIGH) begin
            comfort = COMFORT_HUMID;
        end else begin
            comfort = COMFORT_DRY;
        end

        o_dec.report     = 1'b1;
        o_dec.kind       = KIND_NOMINAL;
        o_dec.confidence = CONF_NOMINAL;
        o_dec.comfort    = COMFORT_OK;
        o_dec.delta      = '0;
        if (t_ch) begin
            o_dec.kind       = KIND_THERMAL;
            o_dec.confidence = CONF_THERMAL;
            o_dec.delta      = {{2{dt[15]}}, dt};
        end else if (p_ch) begin
            o_dec.kind       = KIND_PRESSURE;
            o_dec.confidence = CONF_PRESSURE;
            o_dec.delta      = dp;
        end else if (h_ch) begin
            o_dec.kind       = KIND_HUMIDITY;
            o_dec.confidence = CONF_HUMIDITY;
            o_dec.delta      = {{3{dh[14]}}, dh};
        end else if (first || beat) begin
            o_dec.comfort = comfort;
        end else begin
            o_dec.report = 1'b0;
        end
        // positive delta only; zero and negative leave it low
        o_dec.rising = !o_dec.delta[17] && (|o_dec.delta);
    end

endmodule

### rtl/sensor_change_reporter.sv
// Top level of the sensor change reporter: send-on-delta reports with a heartbeat.
//
// Each input word (temperature, humidity, pressure, millisecond timestamp) is
// compared with the previous sample. A change that reaches its threshold gives
// one change report, by priority temperature, then pressure, then humidity,
// with the signed delta, its direction and a fixed confidence. Otherwise a
// nominal report with a comfort class goes out on the first sample after reset
// or once the heartbeat interval has elapsed since the last report (the
// timestamp difference wraps modulo 2^32). A sample that triggers nothing gives
// no output word but still becomes the new previous sample. The block is a
// two-stage pipeline: an input register, then combinational compare and select
// against the held history into the output register. It takes one word per
// cycle unless a reporting word waits on a stalled output; a result holds
// while the output is stalled. Threshold registers are written through the
// configuration channel (index 0 temperature, 1 humidity, 2 pressure,
// 3 heartbeat) and are always ready; write them only while the block is idle.
module sensor_change_reporter
    import scr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [14:0] i_temperature,
    input  logic [13:0] i_humidity,
    input  logic [16:0] i_pressure,
    input  logic [31:0] i_now_ms,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic        o_rising,
    output logic [17:0] o_delta,
    output logic [2:0]  o_comfort,
    output logic [6:0]  o_confidence,
    output logic [31:0] o_sequence_res,
    output logic [14:0] o_temp_echo,
    output logic [13:0] o_hum_echo,
    output logic [16:0] o_pres_echo
);

`include "sensor_change_reporter_assert.svh"

    // configuration
    t_cfg        r_cfg;

    // input stage
    logic        r_s1_valid;
    t_sample     r_s1;

    // history
    t_history    r_hist;
    logic [31:0] r_count;

    // output stage
    logic        r_out_valid;
    t_decision   r_out_dec;
    logic [31:0] r_out_seq;
    t_sample     r_out_smp;

    t_decision   dec;
    logic        out_free;
    logic        s1_go;
    logic        s1_report;
    logic [31:0] n_count;

    scr_eval u_eval (
        .i_sample (r_s1),
        .i_hist   (r_hist),
        .i_cfg    (r_cfg),
        .o_dec    (dec)
    );

    // An item with no report never needs the output slot, so let it retire
    // even while the output word is stalled.
    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        s1_go       = r_s1_valid && (out_free || !dec.report);
        s1_report   = s1_go && dec.report;
        n_count     = r_count + 32'd1;
        o_in_ready  = !r_s1_valid || s1_go;
        o_cfg_ready = 1'b1;
    end

    // Write threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_threshold     <= TEMP_THR_RESET;
            r_cfg.hum_threshold      <= HUM_THR_RESET;
            r_cfg.pres_threshold     <= PRES_THR_RESET;
            r_cfg.heartbeat_interval <= HEARTBEAT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TEMP_THR:  r_cfg.temp_threshold     <= i_cfg_data[13:0];
                REG_HUM_THR:   r_cfg.hum_threshold      <= i_cfg_data[13:0];
                REG_PRES_THR:  r_cfg.pres_threshold     <= i_cfg_data[16:0];
                REG_HEARTBEAT: r_cfg.heartbeat_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1.temperature <= i_temperature;
            r_s1.humidity    <= i_humidity;
            r_s1.pressure    <= i_pressure;
            r_s1.now_ms      <= i_now_ms;
        end
    end

    // Advance history: every retired sample becomes the previous one,
    // and only a report moves the report time and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_count <= '0;
        end else if (s1_go) begin
            r_hist.temperature   <= r_s1.temperature;
            r_hist.humidity      <= r_s1.humidity;
            r_hist.pressure      <= r_s1.pressure;
            r_hist.have_previous <= 1'b1;
            if (dec.report) begin
                r_hist.last_report_time <= r_s1.now_ms;
                r_count                 <= n_count;
            end
        end
    end

    // Load or drain the output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_report) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_report) begin
            r_out_dec <= dec;
            r_out_seq <= n_count;
            r_out_smp <= r_s1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_dec.kind;
    assign o_rising       = r_out_dec.rising;
    assign o_delta        = r_out_dec.delta;
    assign o_comfort      = r_out_dec.comfort;
    assign o_confidence   = r_out_dec.confidence;
    assign o_sequence_res = r_out_seq;
    assign o_temp_echo    = r_out_smp.temperature;
    assign o_hum_echo     = r_out_smp.humidity;
    assign o_pres_echo    = r_out_smp.pressure;

    `SCR_ASSERT_NOW(a_first_reports, r_s1_valid && !r_hist.have_previous, dec.report)
    `SCR_ASSERT_NEXT(a_count_step, s1_report, r_count == $past(r_count) + 32'd1)
    `SCR_ASSERT_NEXT(a_seq_matches, s1_report, r_out_seq == r_count)
    `SCR_ASSERT_NOW(a_nominal_flat, r_out_valid && (r_out_dec.kind == KIND_NOMINAL),
                    (r_out_dec.delta == '0) && !r_out_dec.rising)
    `SCR_ASSERT_NOW(a_change_no_comfort, r_out_valid && (r_out_dec.kind != KIND_NOMINAL),
                    r_out_dec.comfort == COMFORT_OK)

endmodule
